### rtl/core/pulse_counted_actuator_positioner_defines.svh
// Assertion macros for the pulse counted actuator positioner.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PULSE_COUNTED_ACTUATOR_POSITIONER_DEFINES_SVH
`define PULSE_COUNTED_ACTUATOR_POSITIONER_DEFINES_SVH
`ifndef SYNTHESIS
`define PCAP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCAP_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define PCAP_ASSERT(label, clk, rst_n, prop, msg)
`define PCAP_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

### rtl/core/pcap_pkg.sv
// Shared types and constants for the pulse counted actuator positioner.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pcap_pkg;

  localparam int unsigned POS_WIDTH_DEFAULT = 16;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned TARGET_W = 9;
  localparam int unsigned GOAL_SHIFT = 8;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd500;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PULSE = 2'd1,
    FUNC_GOTO  = 2'd2,
    FUNC_START = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SEEK     = 2'd1,
    PH_MEASURE  = 2'd2,
    PH_POSITION = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    func_e               func;
    logic [TARGET_W-1:0] target;
  } item_t;

endpackage

### rtl/core/pcap_goal.sv
// Scales a goal fraction in 256ths by the travel range and clamps it.
// Depends on pcap_pkg for the fraction width and shift.
`timescale 1ns / 1ps

module pcap_goal #(
  parameter int unsigned POS_WIDTH = pcap_pkg::POS_WIDTH_DEFAULT
) (
  input  logic [pcap_pkg::TARGET_W-1:0] goal_i,
  input  logic [POS_WIDTH-1:0]          range_i,
  output logic [POS_WIDTH-1:0]          goal_pos_o
);

  localparam int unsigned ProdW = POS_WIDTH + pcap_pkg::TARGET_W;

  logic [ProdW-1:0]       prod;
  logic [ProdW-pcap_pkg::GOAL_SHIFT-1:0] scaled;

  assign prod   = ProdW'(goal_i) * ProdW'(range_i);
  assign scaled = prod[ProdW-1:pcap_pkg::GOAL_SHIFT];

  // Bits above the position width mean the goal lies past the counter limit.
  always_comb begin
    if (scaled[ProdW-pcap_pkg::GOAL_SHIFT-1:POS_WIDTH] != '0) begin
      goal_pos_o = '1;
    end else begin
      goal_pos_o = scaled[POS_WIDTH-1:0];
    end
  end

endmodule

### rtl/core/pcap_core.sv
// State registers and single pass update of the positioner for one beat.
// Depends on pcap_pkg and pcap_goal.
`timescale 1ns / 1ps

module pcap_core #(
  parameter int unsigned POS_WIDTH = pcap_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcap_pkg::TIMER_W-1:0] cfg_wdata_i,
  input  logic                         step_i,
  input  pcap_pkg::item_t              item_i,
  output logic                         up_o,
  output logic                         down_o,
  output logic [POS_WIDTH-1:0]         pos_o,
  output logic [POS_WIDTH-1:0]         range_o,
  output pcap_pkg::phase_e             phase_o,
  output pcap_pkg::dir_e               dir_o
);

  localparam logic [POS_WIDTH-1:0] PosMax = '1;

  logic [pcap_pkg::TIMER_W-1:0]  ticks_q;
  pcap_pkg::phase_e              phase_q, phase_d;
  logic [POS_WIDTH-1:0]          pos_q, pos_d;
  logic [POS_WIDTH-1:0]          range_q, range_d;
  logic [pcap_pkg::TARGET_W-1:0] goal_q, goal_d;
  pcap_pkg::dir_e                dir_q, dir_d;
  logic [pcap_pkg::TIMER_W-1:0]  left_q, left_d;
  logic                          armed_q, armed_d;
  logic                          up_q, up_d;
  logic                          down_q, down_d;

  logic [pcap_pkg::TARGET_W-1:0] goal_sel;
  logic [POS_WIDTH-1:0]          range_sel;
  logic [POS_WIDTH-1:0]          goal_pos;
  logic [POS_WIDTH-1:0]          pos_inc;
  logic [POS_WIDTH-1:0]          pos_dec;
  logic [POS_WIDTH-1:0]          pos_new;

  assign goal_sel  = (item_i.func == pcap_pkg::FUNC_GOTO) ? item_i.target : goal_q;
  assign range_sel = (item_i.func == pcap_pkg::FUNC_TICK && phase_q == pcap_pkg::PH_MEASURE)
                   ? pos_q : range_q;

  pcap_goal #(
    .POS_WIDTH (POS_WIDTH)
  ) u_goal (
    .goal_i     (goal_sel),
    .range_i    (range_sel),
    .goal_pos_o (goal_pos)
  );

  assign pos_inc = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
  assign pos_dec = (pos_q == '0) ? pos_q : pos_q - 1'b1;
  assign pos_new = (dir_q == pcap_pkg::DIR_UP) ? pos_inc : pos_dec;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    range_d = range_q;
    goal_d  = goal_q;
    dir_d   = dir_q;
    left_d  = left_q;
    armed_d = armed_q;
    up_d    = up_q;
    down_d  = down_q;
    unique case (item_i.func)
      pcap_pkg::FUNC_TICK: begin
        if (armed_q) begin
          if (left_q <= pcap_pkg::TIMER_W'(1)) begin
            left_d  = '0;
            armed_d = 1'b0;
            dir_d   = pcap_pkg::DIR_STOP;
            up_d    = 1'b0;
            down_d  = 1'b0;
            unique case (phase_q)
              pcap_pkg::PH_SEEK: begin
                pos_d   = '0;
                phase_d = pcap_pkg::PH_MEASURE;
                armed_d = 1'b1;
                left_d  = ticks_q;
                up_d    = 1'b1;
              end
              pcap_pkg::PH_MEASURE: begin
                range_d = pos_q;
                phase_d = pcap_pkg::PH_POSITION;
                if (pos_q != '0) begin
                  if (goal_pos > pos_q) begin
                    dir_d   = pcap_pkg::DIR_UP;
                    armed_d = 1'b1;
                    left_d  = ticks_q;
                    up_d    = 1'b1;
                  end else if (goal_pos < pos_q) begin
                    dir_d   = pcap_pkg::DIR_DOWN;
                    armed_d = 1'b1;
                    left_d  = ticks_q;
                    down_d  = 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end else begin
            left_d = left_q - 1'b1;
          end
        end
      end
      pcap_pkg::FUNC_PULSE: begin
        unique case (phase_q)
          pcap_pkg::PH_SEEK: begin
            armed_d = 1'b1;
            left_d  = ticks_q;
          end
          pcap_pkg::PH_MEASURE: begin
            armed_d = 1'b1;
            left_d  = ticks_q;
            pos_d   = pos_inc;
          end
          pcap_pkg::PH_POSITION: begin
            if (dir_q != pcap_pkg::DIR_STOP) begin
              pos_d   = pos_new;
              armed_d = 1'b1;
              left_d  = ticks_q;
              if ((dir_q == pcap_pkg::DIR_UP && pos_new >= goal_pos) ||
                  (dir_q != pcap_pkg::DIR_UP && pos_new <= goal_pos)) begin
                dir_d   = pcap_pkg::DIR_STOP;
                up_d    = 1'b0;
                down_d  = 1'b0;
                armed_d = 1'b0;
                left_d  = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      pcap_pkg::FUNC_GOTO: begin
        goal_d = item_i.target;
        if (phase_q == pcap_pkg::PH_POSITION && range_q != '0) begin
          dir_d   = pcap_pkg::DIR_STOP;
          up_d    = 1'b0;
          down_d  = 1'b0;
          armed_d = 1'b0;
          left_d  = '0;
          if (goal_pos > pos_q) begin
            dir_d   = pcap_pkg::DIR_UP;
            armed_d = 1'b1;
            left_d  = ticks_q;
            up_d    = 1'b1;
          end else if (goal_pos < pos_q) begin
            dir_d   = pcap_pkg::DIR_DOWN;
            armed_d = 1'b1;
            left_d  = ticks_q;
            down_d  = 1'b1;
          end
        end
      end
      pcap_pkg::FUNC_START: begin
        dir_d   = pcap_pkg::DIR_STOP;
        phase_d = pcap_pkg::PH_SEEK;
        armed_d = 1'b1;
        left_d  = ticks_q;
        up_d    = 1'b0;
        down_d  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= pcap_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pcap_pkg::PH_IDLE;
      pos_q   <= '0;
      range_q <= '0;
      goal_q  <= '0;
      dir_q   <= pcap_pkg::DIR_STOP;
      left_q  <= '0;
      armed_q <= 1'b0;
      up_q    <= 1'b0;
      down_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      range_q <= range_d;
      goal_q  <= goal_d;
      dir_q   <= dir_d;
      left_q  <= left_d;
      armed_q <= armed_d;
      up_q    <= up_d;
      down_q  <= down_d;
    end
  end

  assign up_o    = up_d;
  assign down_o  = down_d;
  assign pos_o   = pos_d;
  assign range_o = range_d;
  assign phase_o = phase_d;
  assign dir_o   = dir_d;

endmodule

### rtl/core/pulse_counted_actuator_positioner.sv
// An input beat is held in the input register until advance, then its result is registered.
// Throughput: one beat per cycle while out_ready_i is high; the input and result registers
// are each refilled in the cycle they are emptied, with one state update per beat.
// Reset: rst_ni is asynchronous and active low; it empties both registers,
// puts the positioner in idle with zero position and range, and loads 500 ticks.
// Depends on pcap_pkg, pcap_core and the assertion macro header.
`timescale 1ns / 1ps
`include "pulse_counted_actuator_positioner_defines.svh"

module pulse_counted_actuator_positioner #(
  parameter int unsigned POS_WIDTH = pcap_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcap_pkg::TIMER_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [pcap_pkg::TARGET_W-1:0] target_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          drive_up_o,
  output logic                          drive_down_o,
  output logic [POS_WIDTH-1:0]          position_o,
  output logic [POS_WIDTH-1:0]          travel_range_o,
  output logic [1:0]                    phase_o,
  output logic [1:0]                    direction_o
);

  logic             in_valid_q;
  pcap_pkg::item_t  item_q;
  logic             out_valid_q;
  logic             advance;

  logic                 nxt_up, nxt_down;
  logic [POS_WIDTH-1:0] nxt_pos, nxt_range;
  pcap_pkg::phase_e     nxt_phase;
  pcap_pkg::dir_e       nxt_dir;

  logic                 res_up_q, res_down_q;
  logic [POS_WIDTH-1:0] res_pos_q, res_range_q;
  pcap_pkg::phase_e     res_phase_q;
  pcap_pkg::dir_e       res_dir_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func   <= pcap_pkg::func_e'(func_i);
      item_q.target <= target_i;
    end
    if (advance) begin
      res_up_q    <= nxt_up;
      res_down_q  <= nxt_down;
      res_pos_q   <= nxt_pos;
      res_range_q <= nxt_range;
      res_phase_q <= nxt_phase;
      res_dir_q   <= nxt_dir;
    end
  end

  pcap_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (item_q),
    .up_o        (nxt_up),
    .down_o      (nxt_down),
    .pos_o       (nxt_pos),
    .range_o     (nxt_range),
    .phase_o     (nxt_phase),
    .dir_o       (nxt_dir)
  );

  assign out_valid_o    = out_valid_q;
  assign drive_up_o     = res_up_q;
  assign drive_down_o   = res_down_q;
  assign position_o     = res_pos_q;
  assign travel_range_o = res_range_q;
  assign phase_o        = res_phase_q;
  assign direction_o    = res_dir_q;

  `PCAP_ASSERT_NEVER(a_drive_exclusive, clk_i, rst_ni,
                     out_valid_q && res_up_q && res_down_q,
                     "Both motor outputs driven in one result beat.")
  `PCAP_ASSERT(a_dir_only_positioning, clk_i, rst_ni,
               (out_valid_q && res_dir_q != pcap_pkg::DIR_STOP) |->
                 (res_phase_q == pcap_pkg::PH_POSITION),
               "Positioning direction set outside the positioning phase.")
  `PCAP_ASSERT(a_range_not_idle, clk_i, rst_ni,
               (out_valid_q && res_range_q != '0) |-> (res_phase_q != pcap_pkg::PH_IDLE),
               "Travel range known while still idle.")
  `PCAP_ASSERT(a_seek_drives_down, clk_i, rst_ni,
               (out_valid_q && res_phase_q == pcap_pkg::PH_SEEK) |-> (res_down_q && !res_up_q),
               "Bottom seek without downward drive.")

endmodule
